[rtl/mbtcp_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus TCP read responder package
// Shared types, limits and codes for the read-holding-register responder.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEFAULT = 128;
   localparam int MAX_COUNT_DEFAULT   = 59;

   // Widest table address over the parameter range (up to 4096 entries)
   localparam int ADDR_MAX_W = 12;
   // Register count after range checks (MAX_COUNT is at most 63)
   localparam int CNT_W      = 6;

   // Queue depths between the parts
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   // Protocol constants
   localparam logic [7:0]  READ_HOLDING_FN = 8'h03;
   localparam logic [16:0] MBAP_PREFIX     = 17'd6;
   localparam logic [15:0] RSP_LEN_BASE    = 16'd3;

   // Input opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [6:0]  table_index;
      logic [15:0] table_value;
      logic [15:0] transaction_id;
      logic [15:0] protocol_id;
      logic [15:0] length_field;
      logic [7:0]  unit_id;
      logic [7:0]  function_code;
      logic [15:0] start_register;
      logic [15:0] register_count;
      logic [4:0]  frame_length;
   } req_type;

   typedef struct packed {
      logic        is_header;
      logic [15:0] resp_transaction;
      logic [15:0] resp_protocol;
      logic [15:0] resp_length;
      logic [7:0]  resp_unit;
      logic [7:0]  resp_function;
      logic [7:0]  resp_byte_count;
      logic [15:0] resp_word;
      logic        last;
   } rsp_type;

   // Classified command passed from the front end to the back end
   typedef struct packed {
      logic                  is_load;
      logic [ADDR_MAX_W-1:0] addr;
      logic [15:0]           value;
      logic [15:0]           transaction;
      logic [15:0]           protocol;
      logic [7:0]            unit;
      logic [7:0]            function_code;
      logic [CNT_W-1:0]      count;
   } cmd_type;

endpackage

[rtl/mbtcp_fifo.sv]
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out queue of DEPTH entries with push/full and pop/empty.
// ----------------------------------------------------------------------------
module mbtcp_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  item_type                   push_data,
   output logic                       full,
   input  logic                       pop,
   output item_type                   head,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   item_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign count   = count_ff;
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload in the slot at the write pointer
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/mbtcp_front.sv]
// ----------------------------------------------------------------------------
// Modbus TCP responder front end
// Accepts input items, checks requests and loads, and queues kept commands.
// ----------------------------------------------------------------------------
module mbtcp_front #(
   parameter int TABLE_DEPTH = mbtcp_pkg::TABLE_DEPTH_DEFAULT,
   parameter int MAX_COUNT   = mbtcp_pkg::MAX_COUNT_DEFAULT
) (
   input  logic              req_push,
   input  mbtcp_pkg::req_type req_data,
   output logic              req_full,
   output logic              cmd_push,
   output mbtcp_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);
   import mbtcp_pkg::*;

   logic len_ok, fn_ok, cnt_ok, start_ok, range_ok;
   logic load_ok, read_ok, keep;

   // Check the request against the frame and the table bounds
   assign len_ok   = ((17'(req_data.length_field) + MBAP_PREFIX) ==
                      17'(req_data.frame_length));
   assign fn_ok    = (req_data.function_code == READ_HOLDING_FN);
   assign cnt_ok   = (32'(req_data.register_count) <= MAX_COUNT);
   assign start_ok = (req_data.start_register != 16'd0);
   assign range_ok = ((32'(req_data.start_register) - 32'd1 +
                       32'(req_data.register_count)) <= TABLE_DEPTH);
   assign read_ok  = len_ok && fn_ok && cnt_ok && start_ok && range_ok;
   assign load_ok  = (32'(req_data.table_index) < TABLE_DEPTH);
   assign keep     = (req_data.opcode == OP_LOAD) ? load_ok : read_ok;

   // Drop rejected items on transfer; queue the rest
   assign req_full = cmd_full;
   assign cmd_push = req_push && keep && !cmd_full;

   always_comb begin
      cmd_data.is_load       = (req_data.opcode == OP_LOAD);
      cmd_data.addr          = cmd_data.is_load ?
                               ADDR_MAX_W'(req_data.table_index) :
                               ADDR_MAX_W'(req_data.start_register - 16'd1);
      cmd_data.value         = req_data.table_value;
      cmd_data.transaction   = req_data.transaction_id;
      cmd_data.protocol      = req_data.protocol_id;
      cmd_data.unit          = req_data.unit_id;
      cmd_data.function_code = req_data.function_code;
      cmd_data.count         = CNT_W'(req_data.register_count);
   end

endmodule

[rtl/mbtcp_back.sv]
// ----------------------------------------------------------------------------
// Modbus TCP responder back end
// Holds the register table, applies loads and streams response items.
// ----------------------------------------------------------------------------
module mbtcp_back #(
   parameter int TABLE_DEPTH = mbtcp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  mbtcp_pkg::cmd_type                         cmd_data,
   input  logic                                       cmd_empty,
   output logic                                       cmd_pop,
   output logic                                       rsp_push,
   output mbtcp_pkg::rsp_type                         rsp_data,
   input  logic [$clog2(mbtcp_pkg::RSP_QUEUE_DEPTH+1)-1:0] rsp_count
);
   import mbtcp_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HDR   = 2'd1;
   localparam logic [1:0] ST_WORDS = 2'd2;

   logic [15:0]      table_mem_ff [TABLE_DEPTH];
   logic [1:0]       state_ff, state_in;
   cmd_type          cur_ff, cur_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             stg_valid_ff, stg_valid_in;
   logic             stg_hdr_ff, stg_hdr_in;
   logic             stg_last_ff, stg_last_in;
   logic [15:0]      rd_word_ff;
   logic             can_issue, word_last;
   logic             mem_we, mem_re;
   logic [ADDR_W-1:0] rd_addr;

   // Room for one more item counting the one in the stage
   assign can_issue = ((32'(rsp_count) + 32'(stg_valid_ff)) < RSP_QUEUE_DEPTH);
   assign word_last = ((idx_ff + 1'b1) == cur_ff.count);
   assign rd_addr   = ADDR_W'(cur_ff.addr + ADDR_MAX_W'(idx_ff));
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
   assign mem_we    = cmd_pop && cmd_data.is_load;
   assign mem_re    = (state_ff == ST_WORDS) && can_issue;

   // Sequence header then one word per cycle while the result queue has room
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      stg_valid_in = 1'b0;
      stg_hdr_in   = stg_hdr_ff;
      stg_last_in  = stg_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && !cmd_data.is_load) begin
               cur_in   = cmd_data;
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (can_issue) begin
               stg_valid_in = 1'b1;
               stg_hdr_in   = 1'b1;
               stg_last_in  = (cur_ff.count == '0);
               idx_in       = '0;
               state_in     = (cur_ff.count == '0) ? ST_IDLE : ST_WORDS;
            end
         end
         ST_WORDS: begin
            if (can_issue) begin
               stg_valid_in = 1'b1;
               stg_hdr_in   = 1'b0;
               stg_last_in  = word_last;
               idx_in       = idx_ff + 1'b1;
               if (word_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stg_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         stg_valid_ff <= stg_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      stg_hdr_ff  <= stg_hdr_in;
      stg_last_ff <= stg_last_in;
   end

   // Register table: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem_ff[ADDR_W'(cmd_data.addr)] <= cmd_data.value;
      end
      if (mem_re) begin
         rd_word_ff <= table_mem_ff[rd_addr];
      end
   end

   // Build the response item from the stage
   assign rsp_push = stg_valid_ff;

   always_comb begin
      rsp_data.is_header = stg_hdr_ff;
      rsp_data.last      = stg_last_ff;
      if (stg_hdr_ff) begin
         rsp_data.resp_transaction = cur_ff.transaction;
         rsp_data.resp_protocol    = cur_ff.protocol;
         rsp_data.resp_length      = RSP_LEN_BASE + {9'd0, cur_ff.count, 1'b0};
         rsp_data.resp_unit        = cur_ff.unit;
         rsp_data.resp_function    = cur_ff.function_code;
         rsp_data.resp_byte_count  = {1'b0, cur_ff.count, 1'b0};
         rsp_data.resp_word        = 16'd0;
      end else begin
         rsp_data.resp_transaction = 16'd0;
         rsp_data.resp_protocol    = 16'd0;
         rsp_data.resp_length      = 16'd0;
         rsp_data.resp_unit        = 8'd0;
         rsp_data.resp_function    = 8'd0;
         rsp_data.resp_byte_count  = 8'd0;
         rsp_data.resp_word        = rd_word_ff;
      end
   end

   // The staged item always finds room in the result queue
   a_stage_room: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff |-> (32'(rsp_count) < RSP_QUEUE_DEPTH))
      else $error("staged item pushed into a full result queue");

   // A header in the stage was issued from the header state
   a_hdr_origin: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_hdr_ff) |-> ($past(state_ff) == ST_HDR))
      else $error("header staged outside the header state");

   // Word index stays within the request count
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORDS) |-> (idx_ff < cur_ff.count))
      else $error("word index ran past the register count");

   // Issuing the last word ends the response
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORDS && can_issue && word_last) |=> (state_ff == ST_IDLE))
      else $error("response did not end after its last word");

endmodule

[rtl/modbus_tcp_read_register_responder.sv]
// ----------------------------------------------------------------------------
// Modbus TCP read-holding-register responder
// Serves function 3 reads from a table of 16-bit words loaded through the
// request channel.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while its two-entry command queue
// has room; loads that fall outside the table and requests that fail the
// frame length, function, count or range checks are dropped there and give
// no results. The back end applies a load as it pops it from the command
// queue. In the back end a request is picked up, then gives the header item
// and one item per register word, paced by the single read port of the table
// memory. Each result is registered in a stage and reaches the result queue
// in the cycle after it is issued, and the four-entry result queue lets the
// back end keep going while results wait to be popped. Table entries must be
// loaded before they are read; there is no clearing pass after reset.
module modbus_tcp_read_register_responder #(
   parameter int TABLE_DEPTH = mbtcp_pkg::TABLE_DEPTH_DEFAULT,
   parameter int MAX_COUNT   = mbtcp_pkg::MAX_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  mbtcp_pkg::req_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output mbtcp_pkg::rsp_type rsp_data
);
   import mbtcp_pkg::*;

   localparam int RSP_CNT_W = $clog2(RSP_QUEUE_DEPTH+1);
   localparam int CMD_CNT_W = $clog2(CMD_QUEUE_DEPTH+1);

   logic                 cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type              cmd_in_data, cmd_head;
   logic [CMD_CNT_W-1:0] cmd_count;
   logic                 out_push, out_full;
   rsp_type              out_data;
   logic [RSP_CNT_W-1:0] out_count;

   // Accept and classify
   mbtcp_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_COUNT   (MAX_COUNT)
   ) u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   // Decouple front and back
   mbtcp_fifo #(
      .item_type (cmd_type),
      .DEPTH     (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   // Apply loads and stream responses
   mbtcp_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (out_push),
      .rsp_data  (out_data),
      .rsp_count (out_count)
   );

   // Hold results until popped
   mbtcp_fifo #(
      .item_type (rsp_type),
      .DEPTH     (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .head      (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   // Command queue occupancy tracks its flags
   a_cmd_flags: assert property (@(posedge clock) disable iff (reset)
      (cmd_empty == (cmd_count == '0)) && (cmd_full == (cmd_count == CMD_CNT_W'(CMD_QUEUE_DEPTH))))
      else $error("command queue flags disagree with occupancy");

   // The back end never pushes into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue overflow");

   // A dropped or accepted item never slips past a full command queue
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      cmd_full |-> !cmd_push)
      else $error("command pushed into a full queue");

endmodule
